// ===== sv/fbfd_pkg.sv =====
// Shared constants, types and configuration register codes of the fire box filter.
package fbfd_pkg;

  localparam int MAX_WIDTH = 512;
  localparam int IDX_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 8;
  localparam int WIDTH_W   = 10;
  localparam int ROW_W     = 10;
  localparam int COL_SUM_W = 10;
  localparam int WIN_SUM_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int OUT_DATA_W = 32;

  // Reciprocal of nine, exact for every window sum below 32768.
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);
  localparam int PROD_W = WIN_SUM_W + RECIP_W - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 2'd2;

  localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = WIDTH_W'(320);
  localparam logic [ROW_W-1:0]   ROW_COUNT_RST  = ROW_W'(50);
  localparam logic [PIX_W-1:0]   DECAY_RST      = PIX_W'(2);
  localparam logic [WIDTH_W-1:0] MIN_WIDTH      = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_V    = WIDTH_W'(MAX_WIDTH);

  // One accepted pixel on its way to the column sum stage.
  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [IDX_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             is_last;
    logic             emit;
  } pix_item_t;

  // Window sums of one pixel that produces results.
  typedef struct packed {
    logic [WIN_SUM_W-1:0] win;
    logic [WIN_SUM_W-1:0] tail;
    logic [IDX_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic                 is_last;
  } win_item_t;

endpackage

// ===== sv/fbfd_line_ram.sv =====
// Line buffer memory holding the two previous rows, one 16-bit entry per column.
module fbfd_line_ram (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [fbfd_pkg::IDX_W-1:0]   rd_addr,
  output logic [2*fbfd_pkg::PIX_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [fbfd_pkg::IDX_W-1:0]   wr_addr,
  input  logic [2*fbfd_pkg::PIX_W-1:0] wr_data
);
  import fbfd_pkg::*;

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/fbfd_column_sum.sv =====
// Line buffer read-modify-write stage that forms the column sums and window sums.
module fbfd_column_sum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pix_valid,
  input  fbfd_pkg::pix_item_t   pix_item,
  output logic                  pix_ready,
  output logic                  win_valid,
  output fbfd_pkg::win_item_t   win_item,
  input  logic                  win_ready
);
  import fbfd_pkg::*;

  logic                 s1_valid_r;
  pix_item_t            s1_item_r;
  logic [2*PIX_W-1:0]   rd_data;
  logic [PIX_W-1:0]     two_above;
  logic [PIX_W-1:0]     one_above;
  logic [COL_SUM_W-1:0] cs1_r;
  logic [COL_SUM_W-1:0] cs2_r;
  logic [COL_SUM_W-1:0] col_sum;
  logic [COL_SUM_W-1:0] prev1;
  logic [COL_SUM_W-1:0] prev2;
  logic                 s1_adv;
  logic                 rd_en;

  // The memory holds {two rows above, one row above} per column. Consecutive
  // pixels always use different columns, and a column is written when its
  // pixel leaves this stage, before the next pixel of that column is read.
  assign rd_en = pix_valid && pix_ready;

  fbfd_line_ram u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (pix_item.col),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_item_r.col),
    .wr_data ({one_above, s1_item_r.px})
  );

  assign two_above = rd_data[2*PIX_W-1:PIX_W];
  assign one_above = rd_data[PIX_W-1:0];
  assign col_sum   = COL_SUM_W'(two_above) + COL_SUM_W'(one_above)
                   + COL_SUM_W'(s1_item_r.px);

  // Sums to the left of column zero read as zero.
  assign prev1 = (s1_item_r.col == '0) ? '0 : cs1_r;
  assign prev2 = (s1_item_r.col == '0) ? '0 : cs2_r;

  assign win_valid = s1_valid_r && s1_item_r.emit;
  assign s1_adv    = s1_valid_r && (!s1_item_r.emit || win_ready);
  assign pix_ready = !s1_valid_r || s1_adv;

  always_comb begin
    win_item.win     = WIN_SUM_W'(prev1) + WIN_SUM_W'(prev2) + WIN_SUM_W'(col_sum);
    win_item.tail    = WIN_SUM_W'(prev2) + WIN_SUM_W'(col_sum);
    win_item.col     = s1_item_r.col - IDX_W'(1);
    win_item.row     = s1_item_r.row - ROW_W'(2);
    win_item.is_last = s1_item_r.is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cs1_r      <= '0;
      cs2_r      <= '0;
    end else begin
      if (rd_en) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        cs1_r <= prev2;
        cs2_r <= col_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_item_r <= pix_item;
    end
  end

endmodule

// ===== sv/fbfd_average.sv =====
// Divide-by-nine, decay and output register; splits a last-column pixel into two words.
module fbfd_average (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [fbfd_pkg::PIX_W-1:0]      decay,
  input  logic                            win_valid,
  input  fbfd_pkg::win_item_t             win_item,
  output logic                            win_ready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fbfd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import fbfd_pkg::*;

  logic                 s2_valid_r;
  logic                 s2_phase_r;
  win_item_t            s2_item_r;
  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_heat_r;
  logic [IDX_W-1:0]     out_col_r;
  logic [ROW_W-1:0]     out_row_r;
  logic                 out_last_r;
  logic                 out_take;
  logic                 pop;
  logic                 done;
  logic                 load;
  logic [WIN_SUM_W-1:0] sel_sum;
  logic [PROD_W-1:0]    prod;
  logic [PIX_W-1:0]     avg;
  logic [PIX_W-1:0]     heat_nxt;
  logic [IDX_W-1:0]     col_nxt;
  logic                 last_nxt;

  assign out_take  = !out_valid_r || out_tready;
  assign pop       = s2_valid_r && out_take;
  assign done      = pop && (!s2_item_r.is_last || s2_phase_r);
  assign win_ready = !s2_valid_r || done;
  assign load      = win_valid && win_ready;

  // The second word of a last column covers only that column and the one before.
  assign sel_sum  = s2_phase_r ? s2_item_r.tail : s2_item_r.win;
  assign col_nxt  = s2_phase_r ? (s2_item_r.col + IDX_W'(1)) : s2_item_r.col;
  assign last_nxt = !s2_item_r.is_last || s2_phase_r;
  assign prod     = PROD_W'(sel_sum) * PROD_W'(RECIP_9);
  assign avg      = prod[RECIP_SHIFT +: PIX_W];
  assign heat_nxt = (avg > decay) ? (avg - decay) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s2_phase_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        s2_valid_r <= 1'b1;
        s2_phase_r <= 1'b0;
      end else if (done) begin
        s2_valid_r <= 1'b0;
        s2_phase_r <= 1'b0;
      end else if (pop) begin
        s2_phase_r <= 1'b1;
      end
      if (out_take) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_item_r <= win_item;
    end
    if (pop) begin
      out_heat_r <= heat_nxt;
      out_col_r  <= col_nxt;
      out_row_r  <= s2_item_r.row;
      out_last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_W'({out_row_r, out_col_r, out_heat_r});

  a_phase_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_phase_r |-> s2_item_r.is_last)
    else $error("second word pending for a pixel that is not in the last column");

  a_first_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_phase_r |-> out_valid_r && !out_last_r)
    else $error("second word pending without the first word in the output register");

  a_pair_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> s2_valid_r && s2_phase_r)
    else $error("non-final word shown without its partner waiting");

endmodule

// ===== sv/fire_box_filter_decay_unit.sv =====
// Top level: 3x3 box average with decay over a raster pixel stream, with line buffers.
// Path: an accepted pixel passes the column sum register, the average register and the
// output register to out_tvalid; the second word of a last column follows the first.
// Throughput: one pixel per cycle while out_tready stays high. The extra word of each
// last column takes the slot of the next row's first column, which gives no word.
// Reset (synchronous, rst_n low): registers go to width 320, 50 rows, decay 2;
// counters and column sums clear; the line buffer memory is not cleared.
module fire_box_filter_decay_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fbfd_pkg::PIX_W-1:0]      in_tdata,   // [7:0] heat_in
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fbfd_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] heat_out, [16:8] out_column,
                                                      // [26:17] out_row, [31:27] zero
  output logic                            out_tlast,  // run_last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbfd_pkg::*;

  logic [WIDTH_W-1:0] line_width_r;
  logic [ROW_W-1:0]   row_count_r;
  logic [PIX_W-1:0]   decay_r;
  logic [IDX_W-1:0]   col_r;
  logic [ROW_W:0]     row_r;
  logic [IDX_W-1:0]   col_nxt;
  logic [ROW_W:0]     row_nxt;
  logic [WIDTH_W-1:0] eff_width;
  logic [ROW_W:0]     last_row;
  logic               last_col;
  logic               accept;
  pix_item_t          pix_item;
  logic               win_valid;
  logic               win_ready;
  win_item_t          win_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      row_count_r  <= ROW_COUNT_RST;
      decay_r      <= DECAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH: line_width_r <= cfg_data;
        CFG_ROW_COUNT:  row_count_r  <= cfg_data;
        CFG_DECAY:      decay_r      <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_width_r < MIN_WIDTH) begin
      eff_width = MIN_WIDTH;
    end else if (line_width_r > MAX_WIDTH_V) begin
      eff_width = MAX_WIDTH_V;
    end else begin
      eff_width = line_width_r;
    end
  end

  // Index of the last input row; a row count of zero acts as one.
  assign last_row = (row_count_r == '0) ? (ROW_W+1)'(2) : ((ROW_W+1)'(row_count_r) + 1'b1);
  assign last_col = WIDTH_W'(col_r) >= (eff_width - WIDTH_W'(1));
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = (row_r >= last_row) ? '0 : (row_r + (ROW_W+1)'(1));
    end else begin
      col_nxt = col_r + IDX_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // The bottom input row of the tallest frame is 1024; its low bits still give the
  // right output row once two is subtracted.
  always_comb begin
    pix_item.px      = in_tdata;
    pix_item.col     = col_r;
    pix_item.row     = row_r[ROW_W-1:0];
    pix_item.is_last = last_col;
    pix_item.emit    = (row_r >= (ROW_W+1)'(2)) && (col_r != '0);
  end

  fbfd_column_sum u_column_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (in_tvalid),
    .pix_item  (pix_item),
    .pix_ready (in_tready),
    .win_valid (win_valid),
    .win_item  (win_item),
    .win_ready (win_ready)
  );

  fbfd_average u_average (
    .clk        (clk),
    .rst_n      (rst_n),
    .decay      (decay_r),
    .win_valid  (win_valid),
    .win_item   (win_item),
    .win_ready  (win_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/testbench.sv =====
// Testbench of the fire box filter: a randomized pixel stream checked against a local filter model.
module testbench;
  import fbfd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind this index
  localparam int WINDOW_TAPS = 9;
  localparam int SETTLE_CYCLES = 4;

  typedef enum int {
    HEAT_RANDOM, HEAT_HOT, HEAT_EXTREME, HEAT_COLD, HEAT_FULL, HEAT_STRIPED
  } heat_mix_t;

  typedef struct packed {
    logic [PIX_W-1:0] heat;
    logic [IDX_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             row_end;
  } heat_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fire_box_filter_decay_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the filter state and registers.
  logic [PIX_W-1:0]     line_two [MAX_WIDTH];
  logic [PIX_W-1:0]     line_one [MAX_WIDTH];
  logic [COL_SUM_W-1:0] col_sums [3] = '{default: '0};
  int                   col_pos = 0;
  int                   row_pos = 0;
  logic [WIDTH_W-1:0]   width_reg = LINE_WIDTH_RST;
  logic [ROW_W-1:0]     rows_reg = ROW_COUNT_RST;
  logic [PIX_W-1:0]     decay_reg = DECAY_RST;

  logic [PIX_W-1:0] old_heat_q[$];
  heat_word_t       new_heat_q[$];
  int               pixels_queued = 0;
  int               pixels_taken = 0;
  int               words_seen = 0;
  int               mismatches = 0;
  logic             pix_taken = 1'b0;
  logic             word_taken = 1'b0;
  int               in_gap = 0;
  int               out_stall = 0;
  int               in_gap_max = 7;
  int               out_stall_max = 7;

  function automatic int eff_width();
    int w;
    w = int'(width_reg);
    if (w < int'(MIN_WIDTH)) w = int'(MIN_WIDTH);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_rows();
    return (rows_reg == 0) ? 1 : int'(rows_reg);
  endfunction

  // Pixels still to send before the filter is back at row zero, column zero.
  function automatic int items_to_frame_end();
    int w;
    int row_left;
    w = eff_width();
    row_left = (col_pos >= w - 1) ? 1 : w - col_pos;
    if (row_pos >= eff_rows() + 1) return row_left;
    return row_left + (eff_rows() + 1 - row_pos) * w;
  endfunction

  function automatic logic [PIX_W-1:0] decayed_heat(input int window);
    int avg;
    avg = window / WINDOW_TAPS;
    if (avg > int'(decay_reg)) return PIX_W'(avg - int'(decay_reg));
    return '0;
  endfunction

  task automatic expect_word(input int window, input int column, input int row,
                             input logic row_end);
    heat_word_t w;
    w.heat    = decayed_heat(window);
    w.column  = column[IDX_W-1:0];
    w.row     = row[ROW_W-1:0];
    w.row_end = row_end;
    new_heat_q.push_back(w);
  endtask

  task automatic filter_pixel(input logic [PIX_W-1:0] px);
    int w;
    int c;
    int r;
    int idx;
    logic row_end;
    logic [COL_SUM_W-1:0] col_total;
    w = eff_width();
    c = col_pos;
    r = row_pos;
    idx = c % MAX_WIDTH;
    row_end = (c >= w - 1);
    col_total = COL_SUM_W'(line_two[idx]) + COL_SUM_W'(line_one[idx]) + COL_SUM_W'(px);
    line_two[idx] = line_one[idx];
    line_one[idx] = px;
    // Neighbors left of column zero count as zero.
    if (c == 0) begin
      col_sums[1] = '0;
      col_sums[2] = '0;
    end
    col_sums[0] = col_sums[1];
    col_sums[1] = col_sums[2];
    col_sums[2] = col_total;
    if (r >= 2 && c >= 1) begin
      expect_word(int'(col_sums[0]) + int'(col_sums[1]) + int'(col_sums[2]), c - 1, r - 2,
                  !row_end);
      // The last column also closes the row, with zero to its right.
      if (row_end) expect_word(int'(col_sums[1]) + int'(col_sums[2]), c, r - 2, 1'b1);
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = (r >= eff_rows() + 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0s mismatch on word %0d: expected %0d, got %0d", what, words_seen, want, got);
    end
  endtask

  // Input side: accept at the rising edge, present the next pixel at the falling edge.
  always @(posedge clk) begin
    pix_taken = rst_n && in_tvalid && in_tready;
    if (pix_taken) begin
      filter_pixel(in_tdata);
      pixels_taken++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || pix_taken) begin
      if (pix_taken) in_gap = $urandom_range(0, in_gap_max);
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (old_heat_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= old_heat_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side.
  always @(posedge clk) begin
    heat_word_t want;
    word_taken = 1'b0;
    if (rst_n && out_tvalid && out_tready) begin
      word_taken = 1'b1;
      words_seen++;
      if (new_heat_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %0d: data %h, last %b", words_seen, out_tdata, out_tlast);
      end else begin
        want = new_heat_q.pop_front();
        check_field("heat_out", int'(want.heat), int'(out_tdata[7:0]));
        check_field("out_column", int'(want.column), int'(out_tdata[16:8]));
        check_field("out_row", int'(want.row), int'(out_tdata[26:17]));
        check_field("padding", 0, int'(out_tdata[31:27]));
        check_field("run_last", int'(want.row_end), int'(out_tlast));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (word_taken) out_stall = $urandom_range(0, out_stall_max);
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_LINE_WIDTH: width_reg = value;
      CFG_ROW_COUNT:  rows_reg = value;
      CFG_DECAY:      decay_reg = value[PIX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pixels(input int count, input heat_mix_t mix);
    logic [PIX_W-1:0] px;
    for (int i = 0; i < count; i++) begin
      case (mix)
        HEAT_HOT:     px = PIX_W'($urandom_range(200, 255));
        HEAT_EXTREME: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        HEAT_COLD:    px = PIX_W'($urandom_range(0, 24));
        HEAT_FULL:    px = 8'hFF;
        HEAT_STRIPED: px = i[0] ? 8'hFF : 8'h00;
        default:      px = PIX_W'($urandom_range(0, 255));
      endcase
      old_heat_q.push_back(px);
      pixels_queued++;
    end
  endtask

  // Wait until every pixel is taken and every word is back, then let the pipe empty.
  task automatic settle();
    @(negedge clk);
    while (pixels_taken != pixels_queued || new_heat_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic finish_frame();
    settle();
    if (col_pos != 0 || row_pos != 0) begin
      queue_pixels(items_to_frame_end(), HEAT_RANDOM);
      settle();
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_decay();
    logic [PIX_W-1:0] d;
    case ($urandom_range(0, 5))
      0:       d = 8'h00;
      1:       d = 8'hFF;
      default: d = PIX_W'($urandom_range(0, 20));
    endcase
    // Upper data bits are ignored by the decay register.
    return {2'($urandom_range(0, 3)), d};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    if ($urandom_range(0, 7) == 0) return CFG_DATA_W'($urandom_range(0, 2));
    return CFG_DATA_W'($urandom_range(3, 12));
  endfunction

  initial begin
    int random_pixels;
    int count;
    random_pixels = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: full heat with no decay, then clamped width and rows under full decay.
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_LINE_WIDTH, 10'd3);
    write_reg(CFG_ROW_COUNT, 10'd1);
    write_reg(CFG_DECAY, 10'h300);
    queue_pixels(9, HEAT_FULL);
    settle();
    write_reg(CFG_LINE_WIDTH, 10'd1);
    write_reg(CFG_ROW_COUNT, 10'd0);
    write_reg(CFG_DECAY, 10'h0FF);
    queue_pixels(9, HEAT_STRIPED);
    settle();

    // Random frames, cut at random points. The width only grows at a frame start,
    // so no result depends on a line buffer entry that has not been written.
    while (random_pixels < 400) begin
      settle();
      in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 7;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      if (col_pos == 0 && row_pos == 0) begin
        if ($urandom_range(0, 3) != 0) write_reg(CFG_LINE_WIDTH, pick_width());
        if ($urandom_range(0, 2) != 0)
          write_reg(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(0, 5)));
        if ($urandom_range(0, 2) != 0) write_reg(CFG_DECAY, pick_decay());
      end else begin
        case ($urandom_range(0, 3))
          0: write_reg(CFG_DECAY, pick_decay());
          1: write_reg(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(0, 5)));
          2: write_reg(CFG_LINE_WIDTH, CFG_DATA_W'($urandom_range(0, eff_width())));
          default: ;
        endcase
      end
      count = items_to_frame_end();
      if ($urandom_range(0, 2) == 0) count = $urandom_range(1, count);
      queue_pixels(count, heat_mix_t'($urandom_range(0, 3)));
      random_pixels += count;
    end

    // Widest lines: a width that clamps to the maximum.
    finish_frame();
    in_gap_max    = 7;
    out_stall_max = 7;
    write_reg(CFG_LINE_WIDTH, 10'h3FF);
    write_reg(CFG_ROW_COUNT, 10'd0);
    write_reg(CFG_DECAY, 10'h101);
    queue_pixels(3 * MAX_WIDTH, HEAT_HOT);
    settle();

    // Tallest frame, cut short by lowering the row count below the current row.
    write_reg(CFG_LINE_WIDTH, 10'd3);
    write_reg(CFG_ROW_COUNT, 10'h3FF);
    write_reg(CFG_DECAY, 10'h000);
    queue_pixels(60, HEAT_RANDOM);
    settle();
    write_reg(CFG_ROW_COUNT, 10'd2);
    queue_pixels(items_to_frame_end(), HEAT_RANDOM);
    settle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fbfd_pkg.sv
sv/fbfd_line_ram.sv
sv/fbfd_column_sum.sv
sv/fbfd_average.sv
sv/fire_box_filter_decay_unit.sv
bench/testbench.sv
